FILE: hdl/plcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plcs_pkg
// Types and constants for the per-channel latency statistics table.
// ----------------------------------------------------------------------------
package plcs_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int CHANNEL_W        = 4;
    localparam int DELAY_W          = 32;
    localparam int COUNT_W          = 32;
    localparam int TOTAL_W          = 48;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PRODUCED = 2'd0;
    localparam kind_t KIND_CONSUMED = 2'd1;
    localparam kind_t KIND_QUERY    = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        kind_t                kind;
        logic [CHANNEL_W-1:0] channel;
        logic [DELAY_W-1:0]   delay;
    } request_t;

    typedef struct packed {
        logic [COUNT_W-1:0] produced_count;
        logic [COUNT_W-1:0] consumed_count;
        logic [DELAY_W-1:0] min_delay;
        logic [DELAY_W-1:0] max_delay;
        logic [TOTAL_W-1:0] total_delay;
    } result_t;

endpackage
`default_nettype wire

FILE: hdl/per_channel_latency_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_channel_latency_stats
// Per-channel produced/consumed counts and min/max/total delay statistics.
//
// Usage:
//   A transaction is taken on a rising edge with start high and busy low;
//   request carries the event kind, the channel and the Q16.16 delay.
//   busy stays low, so a transaction may be issued every cycle.
//   Via valid_reg and then done_reg, done pulses for one cycle and result holds
//   the channel's statistics after the update. Results stream one per cycle.
//   The read-modify-write of the channel row happens in the cycle after
//   acceptance, straight from the row flops, so back-to-back transactions on
//   the same channel see each other's updates.
//   A channel at or above NUM_CHANNELS changes nothing and returns zeros;
//   kind 3 behaves as a query.
//   Reset clears every row to zero immediately; no clearing sweep is needed.
//   The receiver has no flow control and must take each result as it comes.
// ----------------------------------------------------------------------------
module per_channel_latency_stats #(
    parameter int NUM_CHANNELS = plcs_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire plcs_pkg::request_t request,
    output logic                   done,
    output plcs_pkg::result_t      result
);
    import plcs_pkg::*;

    localparam int ROWS  = (NUM_CHANNELS < (1 << CHANNEL_W)) ? NUM_CHANNELS
                                                              : (1 << CHANNEL_W);
    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CMP_W = CHANNEL_W + 5;

    request_t             req_reg;
    logic                 valid_reg;
    result_t              rows_reg [ROWS];
    result_t              row_cur;
    result_t              row_next;
    logic                 in_range;
    logic [IDX_W-1:0]     idx;
    logic [TOTAL_W:0]     sum;
    logic                 row_we;
    result_t              result_reg;
    result_t              result_next;
    logic                 done_reg;

    assign busy = 1'b0;

    // hold the accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
    end

    assign in_range = {{(CMP_W-CHANNEL_W){1'b0}}, req_reg.channel} < CMP_W'(NUM_CHANNELS);
    assign idx      = IDX_W'(req_reg.channel);
    assign row_cur  = rows_reg[idx];
    assign sum      = {1'b0, row_cur.total_delay} + (TOTAL_W+1)'(req_reg.delay);

    always_comb
    begin
        row_next = row_cur;
        row_we   = 1'b0;
        unique case (req_reg.kind)
            KIND_PRODUCED:
            begin
                row_we = 1'b1;
                if (row_cur.produced_count != COUNT_MAX)
                begin
                    row_next.produced_count = row_cur.produced_count + 1'b1;
                end
            end
            KIND_CONSUMED:
            begin
                row_we = 1'b1;
                if (row_cur.consumed_count != COUNT_MAX)
                begin
                    row_next.consumed_count = row_cur.consumed_count + 1'b1;
                end
                if (row_cur.min_delay == '0 || req_reg.delay < row_cur.min_delay)
                begin
                    row_next.min_delay = req_reg.delay;
                end
                if (row_cur.max_delay == '0 || req_reg.delay > row_cur.max_delay)
                begin
                    row_next.max_delay = req_reg.delay;
                end
                row_next.total_delay = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end
            default:
            begin
                row_we = 1'b0;
            end
        endcase
        result_next = in_range ? row_next : '0;
    end

    // advance the row and the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                rows_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            if (valid_reg && in_range && row_we)
            begin
                rows_reg[idx] <= row_next;
            end
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

FILE: hdl/plcs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plcs_checker
// Port-level checks for per_channel_latency_stats, bound into every instance of it.
// ----------------------------------------------------------------------------
module plcs_checker #(
    parameter int NUM_CHANNELS = plcs_pkg::NUM_CHANNELS_DEF
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire plcs_pkg::request_t request,
    input wire logic               done,
    input wire plcs_pkg::result_t  result
);
    import plcs_pkg::*;

    localparam int CMP_W = CHANNEL_W + 5;

    logic accept;
    logic out_of_range;

    assign accept       = start && !busy;
    assign out_of_range = {{(CMP_W-CHANNEL_W){1'b0}}, request.channel} >= CMP_W'(NUM_CHANNELS);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("transaction without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result without transaction");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_of_range) |-> ##2 (result == '0))
        else $error("out-of-range channel returned nonzero result");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.min_delay <= result.max_delay))
        else $error("min delay above max delay");

endmodule

bind per_channel_latency_stats plcs_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
) u_plcs_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);
`default_nettype wire

FILE: bench/per_channel_latency_stats_tb.sv
// ----------------------------------------------------------------------------
// per_channel_latency_stats_tb
// Self-checking bench for the per-channel latency statistics table.
//
// A short directed list covers the zero-means-unset extremes, zero delays, the
// widest delays and the unused kind. Random transactions follow, spread over
// four pacing phases, mostly on a few hot channels so that updates land back
// to back. A local model of the table predicts each returned row, and every
// row is compared field by field in the order it was issued.
// ----------------------------------------------------------------------------
module per_channel_latency_stats_tb;

    import plcs_pkg::*;

    localparam int    NUM_CH           = NUM_CHANNELS_DEF;
    localparam int    CLK_PERIOD       = 12;
    localparam int    RESET_CYCLES     = 11;
    localparam int    DRAIN_CYCLES     = 8;
    localparam int    CYCLE_LIMIT      = 400000;
    localparam int    SAT_CHANNEL      = 7;
    localparam int    RANDOM_PER_PHASE = 213;
    localparam int    REPORT_LIMIT     = 10;
    localparam kind_t KIND_SPARE       = 2'd3;

    typedef struct {
        request_t    ev;
        int unsigned gap_pct;
    } pending_t;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    request_t request = '0;
    logic     done;
    result_t  result;

    logic [COUNT_W-1:0] produced_tbl [NUM_CH];
    logic [COUNT_W-1:0] consumed_tbl [NUM_CH];
    logic [DELAY_W-1:0] min_delay_tbl[NUM_CH];
    logic [DELAY_W-1:0] max_delay_tbl[NUM_CH];
    logic [TOTAL_W-1:0] total_tbl    [NUM_CH];

    pending_t    pending_events[$];
    result_t     expected_rows[$];
    int unsigned kind_issued[4];
    int unsigned issued_count    = 0;
    int unsigned checked_count   = 0;
    int unsigned saturated_count = 0;
    int unsigned mismatch_count  = 0;
    int unsigned unexpected_count = 0;
    int unsigned cycle_count     = 0;

    per_channel_latency_stats #(
        .NUM_CHANNELS(NUM_CH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic result_t apply_event(request_t ev);
        result_t            row;
        int unsigned        ch;
        logic [DELAY_W-1:0] d;
        logic [TOTAL_W:0]   sum;
        row = '0;
        ch  = ev.channel;
        d   = ev.delay;
        if (ch >= NUM_CH)
            return row;
        case (ev.kind)
            KIND_PRODUCED:
            begin
                if (produced_tbl[ch] != COUNT_MAX)
                    produced_tbl[ch] = produced_tbl[ch] + 1'b1;
            end
            KIND_CONSUMED:
            begin
                if (consumed_tbl[ch] != COUNT_MAX)
                    consumed_tbl[ch] = consumed_tbl[ch] + 1'b1;
                if (min_delay_tbl[ch] == '0 || d < min_delay_tbl[ch])
                    min_delay_tbl[ch] = d;
                if (max_delay_tbl[ch] == '0 || d > max_delay_tbl[ch])
                    max_delay_tbl[ch] = d;
                sum = {1'b0, total_tbl[ch]} + (TOTAL_W+1)'(d);
                total_tbl[ch] = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end
            default:
            begin
            end
        endcase
        row.produced_count = produced_tbl[ch];
        row.consumed_count = consumed_tbl[ch];
        row.min_delay      = min_delay_tbl[ch];
        row.max_delay      = max_delay_tbl[ch];
        row.total_delay    = total_tbl[ch];
        return row;
    endfunction

    function automatic request_t random_event();
        request_t    ev;
        int unsigned pick;
        ev = '0;
        if ($urandom_range(99) < 50)
            ev.channel = CHANNEL_W'($urandom_range(3));
        else
            ev.channel = CHANNEL_W'($urandom_range(NUM_CH - 1));
        pick = $urandom_range(99);
        if (pick < 45)
            ev.kind = KIND_CONSUMED;
        else if (pick < 75)
            ev.kind = KIND_PRODUCED;
        else if (pick < 90)
            ev.kind = KIND_QUERY;
        else
            ev.kind = KIND_SPARE;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(3))
                0:       ev.delay = 32'h0000_0000;
                1:       ev.delay = 32'h0000_0001;
                2:       ev.delay = 32'h8000_0000;
                default: ev.delay = 32'hFFFF_FFFF;
            endcase
        end
        else if (pick < 35)
            ev.delay = $urandom_range(15);
        else if (pick < 50)
            ev.delay = {16'hFFFF, 16'($urandom_range(16'hFFFF))};
        else
            ev.delay = $urandom();
        return ev;
    endfunction

    task automatic push_event(kind_t k, logic [CHANNEL_W-1:0] ch, logic [DELAY_W-1:0] d,
                              int unsigned gap_pct);
        pending_t p;
        p.ev.kind    = k;
        p.ev.channel = ch;
        p.ev.delay   = d;
        p.gap_pct    = gap_pct;
        pending_events.push_back(p);
    endtask

    task automatic note_mismatch(string field, logic [TOTAL_W-1:0] want,
                                 logic [TOTAL_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0d] %s mismatch: expected 0x%0h, got 0x%0h",
                     cycle_count, field, want, got);
    endtask

    // Driver: hold start until the transaction is taken, then advance.
    always @(posedge clk or negedge rst_n)
    begin : drive
        pending_t nxt;
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rows.push_back(apply_event(request));
                kind_issued[request.kind]++;
                issued_count++;
            end
            if (!start || !busy)
            begin
                if (pending_events.size() != 0 &&
                    $urandom_range(99) >= pending_events[0].gap_pct)
                begin
                    nxt = pending_events.pop_front();
                    start   <= 1'b1;
                    request <= nxt.ev;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: each result is valid for the single cycle marked by done.
    always @(posedge clk)
    begin : observe
        result_t want;
        if (rst_n && done)
        begin
            if (expected_rows.size() == 0)
            begin
                unexpected_count++;
                if (unexpected_count + mismatch_count <= REPORT_LIMIT)
                    $display("[%0d] result with no transaction outstanding: 0x%0h",
                             cycle_count, result);
            end
            else
            begin
                want = expected_rows.pop_front();
                checked_count++;
                if (result.total_delay == TOTAL_MAX)
                    saturated_count++;
                if (result.produced_count !== want.produced_count)
                    note_mismatch("produced_count", TOTAL_W'(want.produced_count),
                                  TOTAL_W'(result.produced_count));
                if (result.consumed_count !== want.consumed_count)
                    note_mismatch("consumed_count", TOTAL_W'(want.consumed_count),
                                  TOTAL_W'(result.consumed_count));
                if (result.min_delay !== want.min_delay)
                    note_mismatch("min_delay", TOTAL_W'(want.min_delay),
                                  TOTAL_W'(result.min_delay));
                if (result.max_delay !== want.max_delay)
                    note_mismatch("max_delay", TOTAL_W'(want.max_delay),
                                  TOTAL_W'(result.max_delay));
                if (result.total_delay !== want.total_delay)
                    note_mismatch("total_delay", want.total_delay, result.total_delay);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned phase_gap[4];
        phase_gap[0] = 0;
        phase_gap[1] = 47;
        phase_gap[2] = 0;
        phase_gap[3] = 18;
        for (int i = 0; i < NUM_CH; i++)
        begin
            produced_tbl[i]  = '0;
            consumed_tbl[i]  = '0;
            min_delay_tbl[i] = '0;
            max_delay_tbl[i] = '0;
            total_tbl[i]     = '0;
        end
        for (int i = 0; i < 4; i++)
            kind_issued[i] = 0;

        push_event(KIND_QUERY,    4'd0,  32'h0000_0000, 0);
        push_event(KIND_SPARE,    4'd0,  32'hFFFF_FFFF, 0);
        push_event(KIND_CONSUMED, 4'd1,  32'h0000_0000, 0);
        push_event(KIND_CONSUMED, 4'd1,  32'h0000_0005, 0);
        push_event(KIND_CONSUMED, 4'd1,  32'h0000_0000, 0);
        push_event(KIND_CONSUMED, 4'd1,  32'h0000_0003, 0);
        push_event(KIND_QUERY,    4'd1,  32'hAAAA_AAAA, 0);
        push_event(KIND_CONSUMED, 4'd2,  32'hFFFF_FFFF, 0);
        push_event(KIND_CONSUMED, 4'd2,  32'h0000_0001, 0);
        push_event(KIND_CONSUMED, 4'd2,  32'h8000_0000, 0);
        push_event(KIND_CONSUMED, 4'd2,  32'h0000_0000, 0);
        push_event(KIND_PRODUCED, 4'd15, 32'h5555_5555, 0);
        push_event(KIND_PRODUCED, 4'd15, 32'h0000_0000, 0);
        push_event(KIND_CONSUMED, 4'd15, 32'h1234_5678, 0);
        push_event(KIND_SPARE,    4'd15, 32'h0000_0001, 0);
        push_event(KIND_CONSUMED, 4'd15, 32'hAAAA_AAAA, 0);
        push_event(KIND_CONSUMED, 4'd15, 32'h5555_5555, 0);
        push_event(KIND_PRODUCED, 4'd0,  32'hFFFF_FFFF, 0);
        push_event(KIND_CONSUMED, 4'd0,  32'h0001_0000, 0);
        push_event(KIND_QUERY,    4'd15, 32'h0000_0000, 0);

        push_event(KIND_CONSUMED, 4'(SAT_CHANNEL), 32'hFFFF_FFFF, 0);
        push_event(KIND_CONSUMED, 4'(SAT_CHANNEL), 32'h0000_0000, 0);
        push_event(KIND_PRODUCED, 4'(SAT_CHANNEL), 32'h0000_0000, 0);
        push_event(KIND_QUERY,    4'(SAT_CHANNEL), 32'h0000_0000, 0);

        for (int ph = 0; ph < 4; ph++)
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                pending_t p;
                p.ev      = random_event();
                p.gap_pct = phase_gap[ph];
                pending_events.push_back(p);
            end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_events.size() != 0 || start || expected_rows.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Issued %0d transactions: %0d produced, %0d consumed, %0d query, %0d spare kind.",
                 issued_count, kind_issued[KIND_PRODUCED], kind_issued[KIND_CONSUMED],
                 kind_issued[KIND_QUERY], kind_issued[KIND_SPARE]);
        $display("Checked %0d rows over four pacing phases, %0d with a saturated delay total.",
                 checked_count, saturated_count);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_rows.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: per_channel_latency_stats.f
hdl/plcs_pkg.sv
hdl/per_channel_latency_stats.sv
hdl/plcs_checker.sv
bench/per_channel_latency_stats_tb.sv
